@@ rtl/fts_pkg.sv @@
// Shared types, constants and register map of the fan tach scan monitor.
package fts_pkg;

	// field and datapath widths
	localparam int FANS_DEF = 6;
	localparam int EDGE_W   = 6;
	localparam int STEP_W   = 3;
	localparam int CHAN_W   = 3;
	localparam int RPM_W    = 15;
	localparam int TPS_W    = 27;
	localparam int TMO_W    = 24;
	localparam int CNT_W    = 32;
	localparam int ADDR_W   = 5;
	localparam int DATA_W   = 32;
	localparam int REGI_W   = 3;

	localparam logic [RPM_W-1:0]  RPM_SAT    = '1;
	localparam logic [STEP_W-1:0] STEP_SHORT = 3'd2;

	// register indexes
	localparam logic [REGI_W-1:0] REG_TPS       = 3'd0;
	localparam logic [REGI_W-1:0] REG_MIN_RPM   = 3'd1;
	localparam logic [REGI_W-1:0] REG_MAX_RPM   = 3'd2;
	localparam logic [REGI_W-1:0] REG_TMO_TWO   = 3'd3;
	localparam logic [REGI_W-1:0] REG_TMO_OTHER = 3'd4;

	// register reset values
	localparam logic [TPS_W-1:0] TPS_RST       = 27'd1000000;
	localparam logic [RPM_W-1:0] MIN_RPM_RST   = 15'd300;
	localparam logic [RPM_W-1:0] MAX_RPM_RST   = 15'd3000;
	localparam logic [TMO_W-1:0] TMO_TWO_RST   = 24'd50000;
	localparam logic [TMO_W-1:0] TMO_OTHER_RST = 24'd100000;

	typedef enum logic [1:0] {
		PH_ARM,
		PH_WAIT,
		PH_REPORT,
		PH_ADVANCE
	} phase_t;

	typedef struct packed {
		logic [EDGE_W-1:0] tach_edges;
		logic [STEP_W-1:0] speed_step;
	} tick_t;

	typedef struct packed {
		logic [CHAN_W-1:0] channel;
		logic [RPM_W-1:0]  rpm;
		logic              out_of_range;
		logic              scan_last;
	} result_t;

	typedef struct packed {
		logic [TPS_W-1:0] ticks_per_second;
		logic [RPM_W-1:0] min_rpm;
		logic [RPM_W-1:0] max_rpm;
		logic [TMO_W-1:0] timeout_step_two;
		logic [TMO_W-1:0] timeout_other;
	} cfg_t;

	typedef struct packed {
		logic             start;
		logic [CNT_W-1:0] dividend;
		logic [CNT_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [CNT_W-1:0] quotient;
	} div_rsp_t;

endpackage

@@ rtl/fts_cfg.sv @@
// Configuration register file behind the APB-style port.
module fts_cfg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [fts_pkg::ADDR_W-1:0] paddr,
	input  logic [fts_pkg::DATA_W-1:0] pwdata,
	output logic [fts_pkg::DATA_W-1:0] prdata,
	output fts_pkg::cfg_t              cfg
);

	logic [fts_pkg::REGI_W-1:0] idx;
	logic                       wr_en;
	fts_pkg::cfg_t              cfg_q;

	assign idx   = paddr[fts_pkg::ADDR_W-1:2];
	assign wr_en = psel & penable & pwrite;
	assign cfg   = cfg_q;

	// write the addressed register, ignore unknown indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ticks_per_second <= fts_pkg::TPS_RST;
			cfg_q.min_rpm          <= fts_pkg::MIN_RPM_RST;
			cfg_q.max_rpm          <= fts_pkg::MAX_RPM_RST;
			cfg_q.timeout_step_two <= fts_pkg::TMO_TWO_RST;
			cfg_q.timeout_other    <= fts_pkg::TMO_OTHER_RST;
		end else if (wr_en) begin
			case (idx)
				fts_pkg::REG_TPS:       cfg_q.ticks_per_second <= pwdata[fts_pkg::TPS_W-1:0];
				fts_pkg::REG_MIN_RPM:   cfg_q.min_rpm          <= pwdata[fts_pkg::RPM_W-1:0];
				fts_pkg::REG_MAX_RPM:   cfg_q.max_rpm          <= pwdata[fts_pkg::RPM_W-1:0];
				fts_pkg::REG_TMO_TWO:   cfg_q.timeout_step_two <= pwdata[fts_pkg::TMO_W-1:0];
				fts_pkg::REG_TMO_OTHER: cfg_q.timeout_other    <= pwdata[fts_pkg::TMO_W-1:0];
				default: ;
			endcase
		end
	end

	// read back the addressed register
	always_comb begin
		case (idx)
			fts_pkg::REG_TPS:
				prdata = fts_pkg::DATA_W'(cfg_q.ticks_per_second);
			fts_pkg::REG_MIN_RPM:   prdata = fts_pkg::DATA_W'(cfg_q.min_rpm);
			fts_pkg::REG_MAX_RPM:   prdata = fts_pkg::DATA_W'(cfg_q.max_rpm);
			fts_pkg::REG_TMO_TWO:   prdata = fts_pkg::DATA_W'(cfg_q.timeout_step_two);
			fts_pkg::REG_TMO_OTHER: prdata = fts_pkg::DATA_W'(cfg_q.timeout_other);
			default:                prdata = '0;
		endcase
	end

endmodule

@@ rtl/fts_div.sv @@
// Bit-serial restoring divider: one quotient bit per cycle.
module fts_div (
	input  logic              clk,
	input  logic              arst_n,
	input  fts_pkg::div_req_t req,
	output fts_pkg::div_rsp_t rsp
);

	localparam int W     = fts_pkg::CNT_W;
	localparam int STEPW = $clog2(W);
	localparam logic [STEPW-1:0] LastStep = STEPW'(W - 1);

	logic [W-1:0]     rem_q;
	logic [W-1:0]     quo_q;
	logic [W-1:0]     dsr_q;
	logic [STEPW-1:0] step_q;
	logic             busy_q;
	logic             done_q;
	logic [W:0]       trial;
	logic             fits;
	logic [W-1:0]     rem_next;

	// trial subtract of the shifted remainder
	always_comb begin
		trial    = {rem_q, quo_q[W-1]} - {1'b0, dsr_q};
		fits     = ~trial[W];
		rem_next = fits ? trial[W-1:0] : {rem_q[W-2:0], quo_q[W-1]};
	end

	// sequence the steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == LastStep) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// shift remainder and quotient one bit per cycle
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dsr_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= rem_next;
			quo_q <= {quo_q[W-2:0], fits};
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

@@ rtl/fts_scan.sv @@
// Fan scan sequencer: timeout, edge capture, rpm hold and result register.
module fts_scan #(
	parameter int FANS = fts_pkg::FANS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  fts_pkg::cfg_t     cfg,
	input  logic              tick_valid,
	output logic              tick_stall,
	input  fts_pkg::tick_t    tick,
	output logic              result_valid,
	input  logic              result_stall,
	output fts_pkg::result_t  result,
	output fts_pkg::div_req_t div_req,
	input  fts_pkg::div_rsp_t div_rsp
);

	localparam int IDXW = (FANS > 1) ? $clog2(FANS) : 1;
	localparam logic [fts_pkg::CHAN_W-1:0] LastCh = fts_pkg::CHAN_W'(FANS - 1);
	localparam int W = fts_pkg::CNT_W;

	fts_pkg::phase_t phase_q, phase_d;

	logic [fts_pkg::CHAN_W-1:0] chan_q;
	logic [W-1:0]               cnt_q;
	logic [fts_pkg::TMO_W-1:0]  tmo_q;
	logic [FANS-1:0]            first_seen_q;
	logic [W-1:0]               first_value_q [FANS];
	logic [W-1:0]               last_diff_q;
	logic [fts_pkg::RPM_W-1:0]  pend_q;
	logic                       res_valid_q;
	fts_pkg::result_t           res_q;

	logic                       acc;
	logic [IDXW-1:0]            fidx;
	logic [7:0]                 edges8;
	logic                       hit;
	logic                       second;
	logic [W-1:0]               cnt_inc;
	logic [W-1:0]               diff_use;
	logic [fts_pkg::TMO_W-1:0]  tmo_dec;
	logic                       last_fan;
	logic [fts_pkg::RPM_W-1:0]  quo_sat;

	// capture datapath of the current fan
	always_comb begin
		fidx     = chan_q[IDXW-1:0];
		edges8   = 8'(tick.tach_edges);
		hit      = edges8[chan_q];
		second   = hit & first_seen_q[fidx];
		cnt_inc  = cnt_q + 1'b1;
		diff_use = (cnt_inc == first_value_q[fidx]) ? last_diff_q
			: cnt_inc - first_value_q[fidx];
		tmo_dec  = (tmo_q != '0) ? tmo_q - 1'b1 : tmo_q;
		last_fan = (chan_q == LastCh);
		quo_sat  = (|div_rsp.quotient[W-1:fts_pkg::RPM_W]) ? fts_pkg::RPM_SAT
			: div_rsp.quotient[fts_pkg::RPM_W-1:0];
	end

	// hold ticks while dividing or while a report would find the result register full
	always_comb begin
		tick_stall = div_rsp.busy | div_rsp.done |
			((phase_q == fts_pkg::PH_REPORT) & res_valid_q);
		acc = tick_valid & ~tick_stall;
	end

	// next phase and divider request
	always_comb begin
		phase_d          = phase_q;
		div_req.start    = 1'b0;
		div_req.divisor  = diff_use;
		div_req.dividend = ({5'b0, cfg.ticks_per_second} << 5)
			- ({5'b0, cfg.ticks_per_second} << 1);
		if (acc) begin
			case (phase_q)
				fts_pkg::PH_ARM: phase_d = fts_pkg::PH_WAIT;
				fts_pkg::PH_WAIT: begin
					div_req.start = second & (diff_use != '0);
					if (second || tmo_dec == '0) begin
						phase_d = fts_pkg::PH_REPORT;
					end
				end
				fts_pkg::PH_REPORT: phase_d = fts_pkg::PH_ADVANCE;
				default:            phase_d = fts_pkg::PH_ARM;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= fts_pkg::PH_ARM;
		end else begin
			phase_q <= phase_d;
		end
	end

	// advance the scan state on each accepted tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_q       <= '0;
			cnt_q        <= '0;
			tmo_q        <= '0;
			first_seen_q <= '0;
			last_diff_q  <= '0;
			pend_q       <= '0;
		end else begin
			if (div_rsp.done) begin
				pend_q <= quo_sat;
			end
			if (acc) begin
				// restart the count on a completed capture pair
				cnt_q <= (phase_q == fts_pkg::PH_WAIT && second) ? '0 : cnt_inc;
				case (phase_q)
					fts_pkg::PH_ARM: begin
						tmo_q  <= (tick.speed_step == fts_pkg::STEP_SHORT)
							? cfg.timeout_step_two : cfg.timeout_other;
						pend_q <= '0;
					end
					fts_pkg::PH_WAIT: begin
						tmo_q <= tmo_dec;
						if (hit) begin
							if (first_seen_q[fidx]) begin
								first_seen_q[fidx] <= 1'b0;
								last_diff_q        <= diff_use;
								if (diff_use == '0) begin
									pend_q <= '0;
								end
							end else begin
								first_seen_q[fidx] <= 1'b1;
							end
						end
					end
					fts_pkg::PH_REPORT: ;
					default: begin
						chan_q <= last_fan ? '0 : chan_q + 1'b1;
					end
				endcase
			end
		end
	end

	// store the first capture of a fan
	always_ff @(posedge clk) begin
		if (acc && phase_q == fts_pkg::PH_WAIT && hit && !first_seen_q[fidx]) begin
			first_value_q[fidx] <= cnt_inc;
		end
	end

	// result register: fill on report, drop when the beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (acc && phase_q == fts_pkg::PH_REPORT) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && phase_q == fts_pkg::PH_REPORT) begin
			res_q.channel      <= chan_q;
			res_q.rpm          <= pend_q;
			res_q.out_of_range <= (pend_q < cfg.min_rpm) | (pend_q > cfg.max_rpm);
			res_q.scan_last    <= last_fan;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

endmodule

@@ rtl/fan_tach_scan_monitor_unit.sv @@
// Top level of the fan tach scan monitor.
//
// The tick channel (tick_valid, tick_stall, tick) takes one capture-timebase
// tick per beat, with the tach edge flags of all fans and the speed step.
// Fans are visited in turn: arm the timeout, wait for a tach capture pair or
// the timeout, report, advance. A report tick emits one beat on the result
// channel (result_valid, result_stall, result) in the cycle after acceptance.
// Most ticks are taken without a stall. A tick that completes a capture pair
// with a nonzero interval starts the bit-serial rpm divider, which holds
// tick_stall high while it shifts, one quotient bit per cycle, and while it
// loads the result.
// The result register frees the tick side; a report tick is stalled while the
// rpm division runs or the previous result beat is still waiting, so a stalled
// receiver eventually holds the tick channel too.
// Configuration goes through the APB-style port; pready is always high.
// Reset clears the scan to arm on fan 0, restores the register defaults
// and empties the result register.
module fan_tach_scan_monitor_unit #(
	parameter int FANS = fts_pkg::FANS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       tick_valid,
	output logic                       tick_stall,
	input  fts_pkg::tick_t             tick,
	output logic                       result_valid,
	input  logic                       result_stall,
	output fts_pkg::result_t           result,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [fts_pkg::ADDR_W-1:0] paddr,
	input  logic [fts_pkg::DATA_W-1:0] pwdata,
	output logic [fts_pkg::DATA_W-1:0] prdata,
	output logic                       pready
);

	localparam logic [fts_pkg::CHAN_W-1:0] LastCh = fts_pkg::CHAN_W'(FANS - 1);

	fts_pkg::cfg_t     cfg;
	fts_pkg::div_req_t div_req;
	fts_pkg::div_rsp_t div_rsp;

	assign pready = 1'b1;

	fts_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	fts_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	fts_scan #(
		.FANS (FANS)
	) u_scan (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.tick_valid   (tick_valid),
		.tick_stall   (tick_stall),
		.tick         (tick),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.div_req      (div_req),
		.div_rsp      (div_rsp)
	);

	// no tick may slip in while the divider works
	a_stall_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.busy |-> tick_stall)
		else $error("tick accepted during rpm division");

	// a new division only starts from an idle divider
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy && !div_rsp.done)
		else $error("divider restarted while busy");

	// end-of-scan marks the last fan only
	a_scan_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.scan_last == (result.channel == LastCh)))
		else $error("scan_last does not match channel");

endmodule
